// ===== rtl/rsw_pkg.sv =====
// Shared types and constants for the selective-repeat receive window.
// Used by every module under rtl/; no dependencies.
package rsw_pkg;

    // built window depth (default) and register width
    localparam int WINDOW_DEF = 32;
    localparam int CFG_W      = 6;
    localparam logic [CFG_W-1:0] WIN_SIZE_RST = 6'd32;

    localparam int KIND_W = 2;
    localparam int SEQ_W  = 32;
    localparam int REF_W  = 32;
    localparam int LEN_W  = 11;
    localparam int EV_W   = 2;

    // stream widths, padded to whole bytes
    localparam int S_FIELDS_W = SEQ_W + REF_W + LEN_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = SEQ_W + 1 + REF_W + LEN_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

    // packet kinds
    localparam logic [KIND_W-1:0] KIND_DATA = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FIN  = 2'd1;

    // result events
    localparam logic [EV_W-1:0] EV_ACK     = 2'd0;
    localparam logic [EV_W-1:0] EV_FINACK  = 2'd1;
    localparam logic [EV_W-1:0] EV_DROP    = 2'd2;
    localparam logic [EV_W-1:0] EV_DELIVER = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SEQ_W-1:0]  seq_num;
        logic [REF_W-1:0]  payload_ref;
        logic [LEN_W-1:0]  payload_len;
    } rsw_item_t;

    typedef struct packed {
        logic [EV_W-1:0]  event_res;
        logic [SEQ_W-1:0] ack_seq;
        logic             ignored;
        logic [REF_W-1:0] payload_ref;
        logic [LEN_W-1:0] payload_len;
        logic             last;
    } rsw_result_t;

    typedef struct packed {
        logic [REF_W-1:0] payload_ref;
        logic [LEN_W-1:0] payload_len;
    } rsw_slot_t;

endpackage

// ===== rtl/rsw_slot_mem.sv =====
// Slot store: payload reference and length per receive slot.
// One write port, one read port with registered read data. Uses rsw_pkg.
module rsw_slot_mem #(
    parameter int DEPTH  = rsw_pkg::WINDOW_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                aclk,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  rsw_pkg::rsw_slot_t  wr_data,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_addr,
    output rsw_pkg::rsw_slot_t  rd_data
);
    import rsw_pkg::*;

    rsw_slot_t mem [DEPTH];
    rsw_slot_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/rsw_out_stage.sv =====
// Output register for result words; parts the window logic from the
// downstream ready. Uses rsw_pkg.
module rsw_out_stage (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rsw_pkg::rsw_result_t in_res,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rsw_pkg::rsw_result_t out_res
);
    import rsw_pkg::*;

    logic        valid_reg;
    rsw_result_t res_reg;

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            res_reg <= in_res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

// ===== rtl/rsw_ctrl.sv =====
// Window control: base, slot marks, fill count, packet evaluation and
// in-order flush through the slot memory. Uses rsw_pkg and rsw_slot_mem.
module rsw_ctrl #(
    parameter int WINDOW = rsw_pkg::WINDOW_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rsw_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  rsw_pkg::rsw_item_t            in_item,
    output logic                          res_valid,
    input  logic                          res_ready,
    output rsw_pkg::rsw_result_t          res
);
    import rsw_pkg::*;

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_FLUSH_RD,
        ST_FLUSH_OUT
    } state_t;

    function automatic logic [CNT_W-1:0] eff_window(input logic [CFG_W-1:0] w);
        logic [CFG_W-1:0] c;
        c = w;
        if (c == '0) c = CFG_W'(1);
        if (c > CFG_W'(WINDOW)) c = CFG_W'(WINDOW);
        return CNT_W'(c);
    endfunction

    state_t             state_reg, state_next;
    logic [SEQ_W-1:0]   base_reg, base_next;
    logic [WINDOW-1:0]  mark_reg, mark_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   rw_reg, rw_next;
    logic [SLOT_W-1:0]  idx_reg, idx_next;
    logic               fin_reg, fin_next;
    rsw_item_t          item_reg;

    rsw_slot_t          mem_wr_data, mem_rd_data;
    logic               mem_wr_en, mem_rd_en;
    logic [SLOT_W-1:0]  slot;

    logic [SEQ_W-1:0]   limit, u_off;
    logic               over, in_range, fresh, full;
    logic [CNT_W-1:0]   idx_inc;
    logic               mark_at_inc, last_del;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);

    // packet evaluation
    assign limit    = base_reg + SEQ_W'(rw_reg);
    assign over     = item_reg.seq_num > limit;
    assign u_off    = item_reg.seq_num - base_reg - SEQ_W'(1);
    assign in_range = u_off < SEQ_W'(rw_reg);
    assign slot     = u_off[SLOT_W-1:0];
    assign fresh    = in_range && !mark_reg[slot];
    assign full     = (cnt_reg == rw_reg);

    // flush end: window exhausted, or for FIN the run of marks ends
    assign idx_inc     = CNT_W'(idx_reg) + CNT_W'(1);
    assign mark_at_inc = (idx_inc < CNT_W'(WINDOW)) ? mark_reg[idx_inc[SLOT_W-1:0]] : 1'b0;
    assign last_del    = (idx_inc == rw_reg) || (fin_reg && !mark_at_inc);

    assign mem_wr_data.payload_ref = item_reg.payload_ref;
    assign mem_wr_data.payload_len = item_reg.payload_len;

    always_comb begin
        state_next = state_reg;
        base_next  = base_reg;
        mark_next  = mark_reg;
        cnt_next   = cnt_reg;
        rw_next    = rw_reg;
        idx_next   = idx_reg;
        fin_next   = fin_reg;
        mem_wr_en  = 1'b0;
        mem_rd_en  = 1'b0;
        res_valid  = 1'b0;
        res        = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid && (in_item.kind == KIND_DATA || in_item.kind == KIND_FIN)) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                res_valid = 1'b1;
                if (item_reg.kind == KIND_FIN) begin
                    res.event_res = EV_FINACK;
                    res.last      = !mark_reg[0];
                end else if (over) begin
                    res.event_res = EV_DROP;
                    res.ack_seq   = item_reg.seq_num;
                    res.last      = !full;
                end else begin
                    res.event_res = EV_ACK;
                    res.ack_seq   = item_reg.seq_num;
                    res.ignored   = !fresh;
                    res.last      = 1'b1;
                end
                if (res_ready) begin
                    state_next = ST_IDLE;
                    idx_next   = '0;
                    if (item_reg.kind == KIND_FIN) begin
                        fin_next = 1'b1;
                        if (mark_reg[0]) begin
                            state_next = ST_FLUSH_RD;
                        end else begin
                            base_next = '0;
                            mark_next = '0;
                            cnt_next  = '0;
                        end
                    end else if (over) begin
                        fin_next = 1'b0;
                        if (full) begin
                            state_next = ST_FLUSH_RD;
                        end
                    end else if (fresh) begin
                        mem_wr_en       = 1'b1;
                        mark_next[slot] = 1'b1;
                        cnt_next        = cnt_reg + CNT_W'(1);
                    end
                end
            end
            ST_FLUSH_RD: begin
                mem_rd_en  = 1'b1;
                state_next = ST_FLUSH_OUT;
            end
            ST_FLUSH_OUT: begin
                res_valid       = 1'b1;
                res.event_res   = EV_DELIVER;
                res.payload_ref = mem_rd_data.payload_ref;
                res.payload_len = mem_rd_data.payload_len;
                res.last        = last_del;
                if (res_ready) begin
                    if (last_del) begin
                        state_next = ST_IDLE;
                        base_next  = fin_reg ? '0 : limit;
                        mark_next  = '0;
                        cnt_next   = '0;
                    end else begin
                        idx_next   = idx_inc[SLOT_W-1:0];
                        state_next = ST_FLUSH_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // register write: new window size, marks dropped, base kept
        if (cfg_valid) begin
            rw_next   = eff_window(cfg_data);
            mark_next = '0;
            cnt_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            base_reg  <= '0;
            mark_reg  <= '0;
            cnt_reg   <= '0;
            rw_reg    <= eff_window(WIN_SIZE_RST);
            idx_reg   <= '0;
            fin_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            base_reg  <= base_next;
            mark_reg  <= mark_next;
            cnt_reg   <= cnt_next;
            rw_reg    <= rw_next;
            idx_reg   <= idx_next;
            fin_reg   <= fin_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= in_item;
        end
    end

    rsw_slot_mem #(
        .DEPTH  (WINDOW),
        .ADDR_W (SLOT_W)
    ) u_slot_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (slot),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (idx_reg),
        .rd_data (mem_rd_data)
    );

    a_cnt_le_window: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= rw_reg)
        else $error("fill count above window size");

    a_cnt_matches_marks: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(mark_reg) == int'(cnt_reg))
        else $error("fill count does not match slot marks");

    a_marks_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (mark_reg >> rw_reg) == '0)
        else $error("slot marked beyond window size");

    a_flush_read_first: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FLUSH_OUT) |->
            ($past(state_reg) == ST_FLUSH_RD || $past(state_reg) == ST_FLUSH_OUT))
        else $error("delivery without slot read");

endmodule

// ===== rtl/selective_receive_window_unit.sv =====
// Ack, drop and finack words go from the EVAL state to the output register and
// on to m_tvalid; no packet is taken until the last word is loaded. s_tready is
// high whenever the window logic is idle, even while a result word waits in the
// output register. A flush delivers one slot at a time (memory read, then output
// load), holding s_tready low until the last slot. Reset (aresetn, synchronous):
// base, marks, count cleared, window size 32 capped at WINDOW; slot memory kept.
module selective_receive_window_unit #(
    parameter int WINDOW = rsw_pkg::WINDOW_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // window_size register
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rsw_pkg::CFG_W-1:0]      cfg_data,
    // packets
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [rsw_pkg::S_TDATA_W-1:0]  s_tdata,  // seq_num, payload_ref, payload_len
    input  logic [rsw_pkg::KIND_W-1:0]     s_tuser,  // kind
    // results
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [rsw_pkg::M_TDATA_W-1:0]  m_tdata,  // ack_seq, ignored, payload_ref, payload_len
    output logic [rsw_pkg::EV_W-1:0]       m_tuser,  // event_res
    output logic                           m_tlast
);
    import rsw_pkg::*;

    rsw_item_t   item;
    rsw_result_t res, out_res;
    logic        res_valid, res_ready;

    assign item.kind        = s_tuser;
    assign item.seq_num     = s_tdata[SEQ_W-1:0];
    assign item.payload_ref = s_tdata[SEQ_W+REF_W-1:SEQ_W];
    assign item.payload_len = s_tdata[S_FIELDS_W-1:SEQ_W+REF_W];

    rsw_ctrl #(
        .WINDOW (WINDOW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    rsw_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_ready  (res_ready),
        .in_res    (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {{M_PAD_W{1'b0}}, out_res.payload_len, out_res.payload_ref,
                      out_res.ignored, out_res.ack_seq};
    assign m_tuser = out_res.event_res;
    assign m_tlast = out_res.last;

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for selective_receive_window_unit: directed table plus random
// packet phases, checked word by word against an in-bench window predictor.
// Depends on rtl/rsw_pkg.sv and rtl/selective_receive_window_unit.sv.
`timescale 1ns / 1ps

module tb_top;
    import rsw_pkg::*;

    localparam int WIN_DEPTH    = WINDOW_DEF;
    localparam int DRAIN_CYCLES = 8;
    localparam int END_CYCLES   = 20;
    localparam int STALL_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 300;
    localparam int NUM_PHASES   = 7;
    localparam logic [KIND_W-1:0] KIND_OTHER = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RSVD  = 2'd3;

    typedef struct {
        bit                is_cfg;
        logic [CFG_W-1:0]  cfg_val;
        rsw_item_t         pkt;
        bit                typed;
        rsw_result_t       res;
    } dir_step_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // seq_num, payload_ref, payload_len
    logic [KIND_W-1:0]    s_tuser;   // kind
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // ack_seq, ignored, payload_ref, payload_len
    logic [EV_W-1:0]      m_tuser;   // event_res
    logic                 m_tlast;

    selective_receive_window_unit #(.WINDOW(WIN_DEPTH)) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // window predictor state
    logic [CFG_W-1:0] win_size;
    logic [SEQ_W-1:0] win_base;
    bit               slot_marked [WIN_DEPTH];
    int               filled;
    rsw_slot_t        slot_store [WIN_DEPTH];

    rsw_result_t next_results [$];
    rsw_result_t expected_words [$];
    dir_step_t   dir_steps [$];

    int error_count;
    int packets_sent;
    int cfg_writes;
    int n_ack, n_ignored, n_drop, n_finack, n_deliver;
    int send_idle_pct;
    int recv_stall_pct;
    int rx_hold_left;
    int stall_cycles;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic int unsigned eff_window();
        int unsigned w;
        w = win_size;
        if (w < 1) w = 1;
        if (w > WIN_DEPTH) w = WIN_DEPTH;
        return w;
    endfunction

    function automatic void clear_marks();
        for (int i = 0; i < WIN_DEPTH; i++) slot_marked[i] = 1'b0;
        filled = 0;
    endfunction

    function automatic void add_result(logic [EV_W-1:0] ev, logic [SEQ_W-1:0] seq,
                                       logic ign, logic [REF_W-1:0] pref,
                                       logic [LEN_W-1:0] plen);
        rsw_result_t r;
        r.event_res   = ev;
        r.ack_seq     = seq;
        r.ignored     = ign;
        r.payload_ref = pref;
        r.payload_len = plen;
        r.last        = 1'b0;
        next_results.push_back(r);
    endfunction

    // Expected result words for one accepted packet; updates the window state.
    function automatic void predict_packet(rsw_item_t p);
        int unsigned      rw;
        logic [SEQ_W-1:0] limit;
        logic [SEQ_W-1:0] slot;
        next_results.delete();
        rw = eff_window();
        if (p.kind == KIND_DATA) begin
            limit = win_base + rw;
            if (p.seq_num > limit) begin
                add_result(EV_DROP, p.seq_num, 1'b0, '0, '0);
                // full window: flush everything, slide base by one window
                if (filled == rw) begin
                    for (int i = 0; i < rw; i++)
                        add_result(EV_DELIVER, '0, 1'b0, slot_store[i].payload_ref,
                                   slot_store[i].payload_len);
                    clear_marks();
                    win_base = win_base + rw;
                end
            end else begin
                slot = p.seq_num - win_base - 1;
                if (slot < rw && !slot_marked[slot]) begin
                    slot_marked[slot] = 1'b1;
                    filled++;
                    slot_store[slot].payload_ref = p.payload_ref;
                    slot_store[slot].payload_len = p.payload_len;
                    add_result(EV_ACK, p.seq_num, 1'b0, '0, '0);
                end else begin
                    add_result(EV_ACK, p.seq_num, 1'b1, '0, '0);
                end
            end
        end else if (p.kind == KIND_FIN) begin
            add_result(EV_FINACK, '0, 1'b0, '0, '0);
            for (int i = 0; i < rw && slot_marked[i]; i++)
                add_result(EV_DELIVER, '0, 1'b0, slot_store[i].payload_ref,
                           slot_store[i].payload_len);
            win_base = '0;
            clear_marks();
        end
        if (next_results.size() > 0) next_results[$].last = 1'b1;
    endfunction

    // Random packet, mostly well-formed traffic around the current window.
    function automatic rsw_item_t make_packet();
        rsw_item_t   p;
        int unsigned rw;
        int          roll;
        int          fin_pct;
        int          first_free;
        rw = eff_window();
        fin_pct = (rw >= 16) ? 2 : 6;
        p.payload_ref = $urandom;
        p.payload_len = $urandom_range(0, 2047);
        roll = $urandom_range(0, 99);
        if (roll < fin_pct) begin
            p.kind = KIND_FIN;
            p.seq_num = $urandom;
        end else if (roll < fin_pct + 5) begin
            p.kind = $urandom_range(0, 1) ? KIND_OTHER : KIND_RSVD;
            p.seq_num = $urandom;
        end else begin
            p.kind = KIND_DATA;
            roll = $urandom_range(0, 99);
            if (roll < 62) begin
                // in order half the time, else anywhere in the window
                first_free = -1;
                for (int i = rw - 1; i >= 0; i--)
                    if (!slot_marked[i]) first_free = i;
                if (first_free >= 0 && $urandom_range(0, 1))
                    p.seq_num = win_base + 1 + first_free;
                else
                    p.seq_num = win_base + 1 + $urandom_range(0, rw - 1);
            end else if (roll < 80) begin
                p.seq_num = win_base + rw + 1 + $urandom_range(0, 3);
            end else if (roll < 90) begin
                p.seq_num = win_base - $urandom_range(0, 5);
            end else begin
                p.seq_num = $urandom;
            end
        end
        return p;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        error_count++;
    endtask

    // Offer one packet; leaves s_tvalid high after the accepting edge.
    task automatic send_packet(input rsw_item_t pkt, input bit typed,
                               input rsw_result_t typed_res);
        @(negedge aclk);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= pkt.kind;
        s_tdata  <= {{(S_TDATA_W - S_FIELDS_W){1'b0}}, pkt.payload_len,
                     pkt.payload_ref, pkt.seq_num};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_packet(pkt);
        if (typed)
            expected_words.push_back(typed_res);
        else
            foreach (next_results[i]) expected_words.push_back(next_results[i]);
        packets_sent++;
    endtask

    // Sender pause until every expected word is out, then let the pipe settle.
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_window(input logic [CFG_W-1:0] val);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        win_size = val;
        clear_marks();
        cfg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic void dir_pkt(logic [KIND_W-1:0] kind, logic [SEQ_W-1:0] seq,
                                    logic [REF_W-1:0] pref, logic [LEN_W-1:0] plen,
                                    bit typed, logic [EV_W-1:0] ev,
                                    logic [SEQ_W-1:0] ack, logic ign);
        dir_step_t s;
        s.is_cfg = 1'b0;
        s.cfg_val = '0;
        s.pkt.kind = kind;
        s.pkt.seq_num = seq;
        s.pkt.payload_ref = pref;
        s.pkt.payload_len = plen;
        s.typed = typed;
        s.res.event_res = ev;
        s.res.ack_seq = ack;
        s.res.ignored = ign;
        s.res.payload_ref = '0;
        s.res.payload_len = '0;
        s.res.last = 1'b1;
        dir_steps.push_back(s);
    endfunction

    function automatic void dir_cfg(logic [CFG_W-1:0] val);
        dir_step_t s;
        s = '{default: '0};
        s.is_cfg = 1'b1;
        s.cfg_val = val;
        dir_steps.push_back(s);
    endfunction

    // result checker
    always @(posedge aclk) begin
        rsw_result_t got;
        rsw_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.event_res   = m_tuser;
            got.ack_seq     = m_tdata[SEQ_W-1:0];
            got.ignored     = m_tdata[SEQ_W];
            got.payload_ref = m_tdata[SEQ_W+REF_W:SEQ_W+1];
            got.payload_len = m_tdata[SEQ_W+REF_W+LEN_W:SEQ_W+REF_W+1];
            got.last        = m_tlast;
            if (expected_words.size() == 0) begin
                report_mismatch($sformatf("unexpected word ev %0d seq %h", got.event_res,
                                          got.ack_seq));
            end else begin
                want = expected_words.pop_front();
                if (got !== want)
                    report_mismatch($sformatf(
                        "ev %0d/%0d seq %h/%h ign %b/%b ref %h/%h len %0d/%0d last %b/%b",
                        got.event_res, want.event_res, got.ack_seq, want.ack_seq,
                        got.ignored, want.ignored, got.payload_ref, want.payload_ref,
                        got.payload_len, want.payload_len, got.last, want.last));
                case (want.event_res)
                    EV_ACK:     if (want.ignored) n_ignored++; else n_ack++;
                    EV_FINACK:  n_finack++;
                    EV_DROP:    n_drop++;
                    EV_DELIVER: n_deliver++;
                endcase
            end
        end
    end

    // watchdog: cycles with no word moving on any channel
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles == STALL_LIMIT) begin
                $display("Timeout: no traffic for %0d cycles", STALL_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold_left > 0) begin
                m_tready <= 1'b0;
                rx_hold_left--;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    initial begin
        logic [CFG_W-1:0] phase_win [NUM_PHASES];
        logic [CFG_W-1:0] wsel;
        int               n_items;
        int               n_directed;
        rsw_result_t      none;

        phase_win = '{6'd3, 6'd8, 6'd1, 6'd32, 6'd16, 6'd0, 6'd5};
        none = '{default: '0};
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        error_count = 0;
        packets_sent = 0;
        cfg_writes = 0;
        n_ack = 0; n_ignored = 0; n_drop = 0; n_finack = 0; n_deliver = 0;
        send_idle_pct = 6;
        recv_stall_pct = 6;
        rx_hold_left = 0;
        stall_cycles = 0;
        win_size = WIN_SIZE_RST;
        win_base = '0;
        clear_marks();

        // window 32 after reset, base 0
        dir_pkt(KIND_DATA, 32'd1, 32'hFFFF_FFFF, 11'd2047, 1, EV_ACK, 32'd1, 1'b0);
        dir_pkt(KIND_DATA, 32'd1, 32'h0, 11'd0, 1, EV_ACK, 32'd1, 1'b1);      // duplicate
        dir_pkt(KIND_DATA, 32'd32, 32'h0, 11'd0, 1, EV_ACK, 32'd32, 1'b0);    // top slot
        dir_pkt(KIND_DATA, 32'd0, 32'h1234_5678, 11'd7, 1, EV_ACK, 32'd0, 1'b1); // stale
        dir_pkt(KIND_DATA, 32'd33, 32'h0, 11'd1, 1, EV_DROP, 32'd33, 1'b0);
        dir_pkt(KIND_DATA, 32'hFFFF_FFFF, 32'h0, 11'd1, 1, EV_DROP, 32'hFFFF_FFFF, 1'b0);
        dir_pkt(KIND_OTHER, 32'd2, 32'hDEAD_BEEF, 11'd5, 0, EV_ACK, '0, 1'b0);
        dir_pkt(KIND_RSVD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 11'd2047, 0, EV_ACK, '0, 1'b0);
        dir_pkt(KIND_DATA, 32'd2, 32'hA5A5_A5A5, 11'h555, 0, EV_ACK, '0, 1'b0);
        dir_pkt(KIND_FIN, 32'd0, 32'h0, 11'd0, 0, EV_ACK, '0, 1'b0);   // leading run only
        dir_pkt(KIND_FIN, 32'd0, 32'h0, 11'd0, 1, EV_FINACK, 32'd0, 1'b0); // empty window
        // single-slot window: full on the first store
        dir_cfg(6'd1);
        dir_pkt(KIND_DATA, 32'd1, 32'h5A5A_5A5A, 11'h2AA, 1, EV_ACK, 32'd1, 1'b0);
        dir_pkt(KIND_DATA, 32'd2, 32'h0, 11'd0, 0, EV_ACK, '0, 1'b0);  // drop and flush
        dir_pkt(KIND_DATA, 32'd2, 32'h0000_FFFF, 11'd100, 1, EV_ACK, 32'd2, 1'b0);
        dir_pkt(KIND_DATA, 32'd1, 32'h0, 11'd0, 1, EV_ACK, 32'd1, 1'b1);
        dir_pkt(KIND_FIN, 32'd0, 32'h0, 11'd0, 0, EV_ACK, '0, 1'b0);
        // four slots filled backwards, then flushed by an out-of-window packet
        dir_cfg(6'd4);
        dir_pkt(KIND_DATA, 32'd4, 32'h4444_4444, 11'd4, 1, EV_ACK, 32'd4, 1'b0);
        dir_pkt(KIND_DATA, 32'd3, 32'h3333_3333, 11'd3, 1, EV_ACK, 32'd3, 1'b0);
        dir_pkt(KIND_DATA, 32'd2, 32'h2222_2222, 11'd2, 1, EV_ACK, 32'd2, 1'b0);
        dir_pkt(KIND_DATA, 32'd1, 32'h1111_1111, 11'd1, 1, EV_ACK, 32'd1, 1'b0);
        dir_pkt(KIND_DATA, 32'd9, 32'h0, 11'd0, 0, EV_ACK, '0, 1'b0);
        dir_pkt(KIND_DATA, 32'd5, 32'h5555_5555, 11'd5, 1, EV_ACK, 32'd5, 1'b0);
        dir_pkt(KIND_FIN, 32'd0, 32'h0, 11'd0, 0, EV_ACK, '0, 1'b0);

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_steps[i]) begin
            if (dir_steps[i].is_cfg)
                write_window(dir_steps[i].cfg_val);
            else
                send_packet(dir_steps[i].pkt, dir_steps[i].typed, dir_steps[i].res);
        end
        n_directed = packets_sent;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wsel = (phase_win[ph] != 0) ? phase_win[ph] : CFG_W'($urandom_range(1, 32));
            write_window(wsel);
            send_idle_pct  = (ph == 3) ? 0 : 6;
            recv_stall_pct = (ph == 3) ? 0 : 6;
            if (ph == 1) rx_hold_left = HOLD_CYCLES;   // output backs up, input stalls
            n_items = (ph == 3) ? 60 : 25;
            for (int k = 0; k < n_items; k++)
                send_packet(make_packet(), 1'b0, none);
        end

        wait_drained();
        repeat (END_CYCLES) @(posedge aclk);

        $display("Sent %0d packets (%0d directed) over %0d window settings",
                 packets_sent, n_directed, cfg_writes);
        $display("Words: %0d acks, %0d ignored, %0d drops, %0d finacks, %0d deliveries",
                 n_ack, n_ignored, n_drop, n_finack, n_deliver);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
